// ----- rtl/core/bbm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bracket balance matcher package
// Shared widths, character codes, bracket kinds and item types.
// ----------------------------------------------------------------------------
package bbm_pkg;

    localparam int POS_W           = 20;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH     = 2;
    localparam int NKIND           = 3;
    localparam int CFG_IDX_W       = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SEL_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SEL_END   = 1'b1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_CURLY  = 2'd1,
        KIND_SQUARE = 2'd2,
        KIND_PAREN  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] open_next;
        logic [POS_W-1:0] close_pos;
        logic             overflow;
    } out_item_t;

    // One classified byte handed from the lexer to the stack engine
    typedef struct packed {
        logic           has_byte;
        logic           finish;
        logic           is_open;
        logic           is_close;
        kind_t          kind;
        logic [POS_W:0] pos;
    } event_t;

    function automatic kind_t open_kind(input logic [7:0] c);
        kind_t k;
        k = KIND_NONE;
        case (c)
            CH_LBRACE: k = KIND_CURLY;
            CH_LBRACK: k = KIND_SQUARE;
            CH_LPAREN: k = KIND_PAREN;
            default:   k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic kind_t close_kind(input logic [7:0] c);
        kind_t k;
        k = KIND_NONE;
        case (c)
            CH_RBRACE: k = KIND_CURLY;
            CH_RBRACK: k = KIND_SQUARE;
            CH_RPAREN: k = KIND_PAREN;
            default:   k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/bbm_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bracket balance matcher queue
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module bbm_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = bbm_pkg::QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  wire logic [W-1:0] wr_data,
    output logic              full,
    input  wire logic         rd_en,
    output logic [W-1:0]      rd_data,
    output logic              empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/bbm_lexer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bracket balance matcher lexer
// Tracks literals and comments, counts offsets and classifies each byte.
// ----------------------------------------------------------------------------
module bbm_lexer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire bbm_pkg::in_item_t item,
    output bbm_pkg::event_t       ev
);

    typedef enum logic [3:0] {
        LX_NORMAL,
        LX_SQ,
        LX_SQ_ESC,
        LX_DQ,
        LX_DQ_ESC,
        LX_SLASH,
        LX_BLOCK,
        LX_BLOCK_STAR,
        LX_LINE
    } lex_t;

    lex_t                    lex_reg, lex_next, lex_step;
    logic [bbm_pkg::POS_W:0] pos_reg, pos_next;
    logic                    skip;
    logic                    is_br;
    logic                    first;
    logic                    has_byte;
    logic                    finish;
    bbm_pkg::kind_t          ok;
    bbm_pkg::kind_t          ck;

    always_comb
    begin
        ok       = bbm_pkg::open_kind(item.ch);
        ck       = bbm_pkg::close_kind(item.ch);
        first    = (pos_reg == '0);
        has_byte = (item.ch != bbm_pkg::CH_NUL);
        finish   = !has_byte || item.last;
        skip     = 1'b1;
        lex_step = lex_reg;

        unique case (lex_reg)
            LX_SQ:
            begin
                if (item.ch == bbm_pkg::CH_SQUOTE)
                    lex_step = LX_NORMAL;
                else if (item.ch == bbm_pkg::CH_BSLASH)
                    lex_step = LX_SQ_ESC;
            end
            LX_SQ_ESC: lex_step = LX_SQ;
            LX_DQ:
            begin
                if (item.ch == bbm_pkg::CH_DQUOTE)
                    lex_step = LX_NORMAL;
                else if (item.ch == bbm_pkg::CH_BSLASH)
                    lex_step = LX_DQ_ESC;
            end
            LX_DQ_ESC: lex_step = LX_DQ;
            LX_BLOCK:
            begin
                if (item.ch == bbm_pkg::CH_STAR)
                    lex_step = LX_BLOCK_STAR;
            end
            LX_BLOCK_STAR:
            begin
                // closing slash is examined again as a comment opener
                if (item.ch == bbm_pkg::CH_SLASH)
                    lex_step = LX_SLASH;
                else if (item.ch != bbm_pkg::CH_STAR)
                    lex_step = LX_BLOCK;
            end
            LX_LINE:
            begin
                if (item.ch == bbm_pkg::CH_NL)
                    lex_step = LX_NORMAL;
            end
            LX_SLASH:
            begin
                if (item.ch == bbm_pkg::CH_STAR)
                    lex_step = LX_BLOCK;
                else if (item.ch == bbm_pkg::CH_SLASH)
                    lex_step = LX_LINE;
                else
                    skip = 1'b0;
            end
            default: skip = 1'b0;
        endcase

        if (!skip)
        begin
            if (item.ch == bbm_pkg::CH_SQUOTE)
                lex_step = LX_SQ;
            else if (item.ch == bbm_pkg::CH_DQUOTE)
                lex_step = LX_DQ;
            else if (item.ch == bbm_pkg::CH_SLASH)
                lex_step = LX_SLASH;
            else
                lex_step = LX_NORMAL;
        end

        // first byte of a text is only checked as a bracket
        if (first)
        begin
            lex_step = lex_reg;
            is_br    = (ok != bbm_pkg::KIND_NONE) || (ck != bbm_pkg::KIND_NONE);
        end
        else
        begin
            is_br = !skip && ((ok != bbm_pkg::KIND_NONE) || (ck != bbm_pkg::KIND_NONE));
        end

        ev.has_byte = has_byte;
        ev.finish   = finish;
        ev.is_open  = has_byte && is_br && (ok != bbm_pkg::KIND_NONE);
        ev.is_close = has_byte && is_br && (ck != bbm_pkg::KIND_NONE);
        ev.kind     = (ok != bbm_pkg::KIND_NONE) ? ok : ck;
        ev.pos      = pos_reg;

        if (finish)
        begin
            lex_next = LX_NORMAL;
            pos_next = '0;
        end
        else
        begin
            lex_next = lex_step;
            pos_next = (pos_reg == '1) ? pos_reg : pos_reg + (bbm_pkg::POS_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_reg <= LX_NORMAL;
            pos_reg <= '0;
        end
        else if (accept)
        begin
            lex_reg <= lex_next;
            pos_reg <= pos_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/bbm_stack.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bracket balance matcher stack
// Offset stack in a memory with a registered top-of-stack read.
// ----------------------------------------------------------------------------
module bbm_stack #(
    parameter int DEPTH = bbm_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic                          pop,
    input  wire logic                          clear,
    input  wire logic [bbm_pkg::POS_W-1:0]     din,
    output logic [$clog2(DEPTH + 1)-1:0]       count,
    output logic [bbm_pkg::POS_W-1:0]          top
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [bbm_pkg::POS_W-1:0] mem [DEPTH];
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             rd_addr;
    logic [bbm_pkg::POS_W-1:0] rd_reg;
    logic [bbm_pkg::POS_W-1:0] byp_data_reg;
    logic                      byp_reg;

    always_comb
    begin
        if (clear)
            cnt_next = '0;
        else if (push)
            cnt_next = cnt_reg + CW'(1);
        else if (pop && (cnt_reg != '0))
            cnt_next = cnt_reg - CW'(1);
        else
            cnt_next = cnt_reg;
        wr_addr = AW'(cnt_reg);
        rd_addr = (cnt_next == '0) ? '0 : AW'(cnt_next - CW'(1));
    end

    // a push lands on the address being read; take the pushed value instead
    assign top   = byp_reg ? byp_data_reg : rd_reg;
    assign count = cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_addr] <= din;
        end
        rd_reg       <= mem[rd_addr];
        byp_data_reg <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            byp_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            byp_reg <= push;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/bbm_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bracket balance matcher engine
// Stacks bracket offsets, picks the enclosing kind and counts to its close.
// ----------------------------------------------------------------------------
module bbm_engine #(
    parameter int STACK_DEPTH = bbm_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      ev_valid,
    input  wire bbm_pkg::event_t           ev,
    output logic                           ev_pop,
    input  wire logic                      res_full,
    output logic                           res_wr,
    output bbm_pkg::out_item_t             res,
    input  wire logic [bbm_pkg::POS_W-1:0] sel_start,
    input  wire logic [bbm_pkg::POS_W-1:0] sel_end
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int NK = bbm_pkg::NKIND;

    typedef enum logic [1:0] {
        PH_STACK,
        PH_MATCH,
        PH_FAIL,
        PH_DONE
    } phase_t;

    phase_t                    phase_reg, phase_next, ph;
    bbm_pkg::kind_t            chosen_reg, chosen_next, ck;
    logic [bbm_pkg::POS_W:0]   nest_reg, nest_next, nest;
    logic                      ovf_reg, ovf_next, ovf;
    logic                      take;
    logic [NK-1:0]             push_v;
    logic [NK-1:0]             pop_v;
    logic                      clear;
    logic [CW-1:0]             cnt_v [NK];
    logic [bbm_pkg::POS_W-1:0] top_v [NK];
    logic                      best_ok;
    logic [bbm_pkg::POS_W-1:0] best_top;
    bbm_pkg::kind_t            best_k;
    logic [bbm_pkg::POS_W-1:0] chosen_top;

    for (genvar g = 0; g < NK; g++)
    begin : g_stack
        bbm_stack #(
            .DEPTH (STACK_DEPTH)
        ) u_stack (
            .clk   (clk),
            .rst_n (rst_n),
            .push  (push_v[g]),
            .pop   (pop_v[g]),
            .clear (clear),
            .din   (ev.pos[bbm_pkg::POS_W-1:0]),
            .count (cnt_v[g]),
            .top   (top_v[g])
        );
    end

    assign take   = ev_valid && !res_full;
    assign ev_pop = take;

    always_comb
    begin
        ph         = phase_reg;
        ck         = chosen_reg;
        nest       = nest_reg;
        ovf        = ovf_reg;
        push_v     = '0;
        pop_v      = '0;
        clear      = 1'b0;
        res_wr     = 1'b0;
        res        = '0;
        best_ok    = 1'b0;
        best_top   = '0;
        best_k     = bbm_pkg::KIND_NONE;
        chosen_top = '0;

        // nearest stack top, over all kinds, at or before the selection start
        for (int i = 0; i < NK; i++)
        begin
            if ((cnt_v[i] != '0) && (top_v[i] <= sel_start) &&
                (!best_ok || (top_v[i] > best_top)))
            begin
                best_ok  = 1'b1;
                best_top = top_v[i];
                best_k   = bbm_pkg::kind_t'(2'(i + 1));
            end
        end

        if (take && ev.has_byte)
        begin
            if ((ph == PH_STACK) && (ev.pos >= {1'b0, sel_end}))
            begin
                if ((sel_start > sel_end) || !best_ok)
                begin
                    ph = PH_FAIL;
                end
                else
                begin
                    ph   = PH_MATCH;
                    ck   = best_k;
                    nest = (bbm_pkg::POS_W + 1)'(1);
                end
            end

            for (int i = 0; i < NK; i++)
            begin
                if (ck == bbm_pkg::kind_t'(2'(i + 1)))
                    chosen_top = top_v[i];
            end

            if (ph == PH_STACK)
            begin
                for (int i = 0; i < NK; i++)
                begin
                    if (ev.kind == bbm_pkg::kind_t'(2'(i + 1)))
                    begin
                        if (ev.is_open)
                        begin
                            if (cnt_v[i] == CW'(STACK_DEPTH))
                            begin
                                ovf = 1'b1;
                                ph  = PH_FAIL;
                            end
                            else
                            begin
                                push_v[i] = 1'b1;
                            end
                        end
                        else if (ev.is_close)
                        begin
                            pop_v[i] = 1'b1;
                        end
                    end
                end
            end
            else if (ph == PH_MATCH)
            begin
                if (ev.is_close && (ev.kind == ck))
                begin
                    if (nest == (bbm_pkg::POS_W + 1)'(1))
                    begin
                        res.found     = 1'b1;
                        res.open_next = chosen_top + bbm_pkg::POS_W'(1);
                        res.close_pos = ev.pos[bbm_pkg::POS_W-1:0];
                        res.overflow  = 1'b0;
                        res_wr        = 1'b1;
                        ph            = PH_DONE;
                    end
                    else
                    begin
                        nest = nest - (bbm_pkg::POS_W + 1)'(1);
                    end
                end
                else if (ev.is_open && (ev.kind == ck))
                begin
                    // hold at the top count
                    if (nest != '1)
                        nest = nest + (bbm_pkg::POS_W + 1)'(1);
                end
            end
        end

        if (take && ev.finish)
        begin
            if (ph != PH_DONE)
            begin
                res_wr       = 1'b1;
                res.found    = 1'b0;
                res.overflow = ovf;
            end
            ph    = PH_STACK;
            ck    = bbm_pkg::KIND_NONE;
            nest  = (bbm_pkg::POS_W + 1)'(1);
            ovf   = 1'b0;
            clear = 1'b1;
        end

        phase_next  = ph;
        chosen_next = ck;
        nest_next   = nest;
        ovf_next    = ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_STACK;
            chosen_reg <= bbm_pkg::KIND_NONE;
            nest_reg   <= (bbm_pkg::POS_W + 1)'(1);
            ovf_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            chosen_reg <= chosen_next;
            nest_reg   <= nest_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/bracket_balance_matcher.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bracket balance matcher
// Finds the balanced bracket pair enclosing a selection in C-like text.
//
// Text enters one byte per item on the input queue (push/full). A zero byte
// or a byte with last set ends a text. Write sel_start and sel_end through
// the cfg port while the block is idle. Each text yields one result item on
// the output queue (empty/pop): on the byte of the matching close if a pair
// is found, else at the end of the text with found 0.
// Throughput: one byte per cycle while full is low. The lexer classifies a
// byte combinationally and the event queue stores it at the accepting edge;
// the engine takes it when the result queue is not full and then does its
// stack push or pop; each stack memory gives its top from a registered read
// port. A result enters the result queue when the engine takes its byte.
// Reset empties both queues and returns lexer and engine to the start of a
// text; the stack memories need no clearing. When the receiver stalls the
// result queue fills, the engine holds, and full rises once two bytes wait
// in the event queue.
// ----------------------------------------------------------------------------
module bracket_balance_matcher #(
    parameter int STACK_DEPTH = bbm_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire bbm_pkg::in_item_t                 data,
    output logic                                   empty,
    input  wire logic                              pop,
    output bbm_pkg::out_item_t                     result,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bbm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bbm_pkg::POS_W-1:0]         cfg_data
);

    localparam int EV_W  = $bits(bbm_pkg::event_t);
    localparam int RES_W = $bits(bbm_pkg::out_item_t);

    logic [bbm_pkg::POS_W-1:0] sel_start_reg;
    logic [bbm_pkg::POS_W-1:0] sel_end_reg;
    bbm_pkg::event_t           ev_in;
    bbm_pkg::event_t           ev_head;
    logic [EV_W-1:0]           ev_rd_data;
    logic                      ev_empty;
    logic                      ev_pop;
    logic                      res_full;
    logic                      res_wr;
    bbm_pkg::out_item_t        res_in;
    logic [RES_W-1:0]          res_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_start_reg <= '0;
            sel_end_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bbm_pkg::REG_SEL_START: sel_start_reg <= cfg_data;
                bbm_pkg::REG_SEL_END:   sel_end_reg   <= cfg_data;
                default:                ;
            endcase
        end
    end

    bbm_lexer u_lexer (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (push && !full),
        .item   (data),
        .ev     (ev_in)
    );

    bbm_fifo #(
        .W     (EV_W),
        .DEPTH (bbm_pkg::QUEUE_DEPTH)
    ) u_ev_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (ev_in),
        .full    (full),
        .rd_en   (ev_pop),
        .rd_data (ev_rd_data),
        .empty   (ev_empty)
    );

    assign ev_head = bbm_pkg::event_t'(ev_rd_data);

    bbm_engine #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev_valid  (!ev_empty),
        .ev        (ev_head),
        .ev_pop    (ev_pop),
        .res_full  (res_full),
        .res_wr    (res_wr),
        .res       (res_in),
        .sel_start (sel_start_reg),
        .sel_end   (sel_end_reg)
    );

    bbm_fifo #(
        .W     (RES_W),
        .DEPTH (bbm_pkg::QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd_data),
        .empty   (empty)
    );

    assign result = bbm_pkg::out_item_t'(res_rd_data);

endmodule
`default_nettype wire

// ----- rtl/core/bbm_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bracket balance matcher checker
// Port-level checks on the result queue, bound to the top level.
// ----------------------------------------------------------------------------
module bbm_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               empty,
    input wire logic               pop,
    input wire bbm_pkg::out_item_t result
);

    // a waiting item stays until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result item dropped before pop");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(result))
        else $error("stalled result item changed");

    // a found pair never reports overflow
    a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.found) |-> !result.overflow)
        else $error("found result carries overflow");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.found) |-> ((result.open_next == '0) && (result.close_pos == '0)))
        else $error("failed result carries nonzero offsets");

endmodule

bind bracket_balance_matcher bbm_checker u_bbm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
`default_nettype wire
